// ===== hw/rtl/vector_rejection_3d_macros.svh =====
// ----------------------------------------------------------------------------
// Vector rejection assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef VECTOR_REJECTION_3D_MACROS_SVH
`define VECTOR_REJECTION_3D_MACROS_SVH

// check that prop holds at every rising edge out of reset
`define VR3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that cond never holds
`define VR3_NEVER(lbl, cond, msg) \
  `VR3_ASSERT(lbl, !(cond), msg)

`endif

// ===== hw/rtl/vr3_pkg.sv =====
// ----------------------------------------------------------------------------
// Vector rejection package
// Widths, payload types, status codes and fixed-point helpers.
// ----------------------------------------------------------------------------
package vr3_pkg;

  localparam int CW    = 32;            // component width
  localparam int FB    = 16;            // fraction bits
  localparam int LSQ_W = 2 * CW;        // squared length
  localparam int SQ_RW = CW + 3;        // square-root remainder
  localparam int QB    = FB + 1;        // quotient magnitude bits
  localparam int DW    = CW + FB;       // dividend magnitude
  localparam int UW    = FB + 3;        // unit component
  localparam int PW    = CW + UW;       // up * unit
  localparam int SUM_W = PW + 2;        // dot sum
  localparam int DTW   = SUM_W - FB;    // dot
  localparam int SCW   = DTW + UW;      // dot * unit
  localparam int SHW   = SCW - FB;      // scaled component
  localparam int DFW   = SHW + 1;       // difference
  localparam int FRAC_M1 = (1 << FB) - 1;

  typedef logic signed [CW-1:0]    comp_t;
  typedef logic signed [UW-1:0]    unit_t;
  typedef logic signed [PW-1:0]    prod_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic signed [DTW-1:0]   dot_t;
  typedef logic signed [SCW-1:0]   scl_t;
  typedef logic signed [SHW-1:0]   shr_t;
  typedef logic signed [DFW-1:0]   diff_t;
  typedef logic [LSQ_W-1:0]        lsq_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO     = 2'd1,
    ST_PARALLEL = 2'd2
  } status_e;

  typedef struct packed {
    comp_t [2:0] up;
    comp_t [2:0] view;
    logic        zero;
  } side_t;

  localparam comp_t COMP_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam comp_t COMP_MIN = {1'b1, {(CW-1){1'b0}}};

  function automatic logic [CW-1:0] mag(comp_t v);
    return v[CW-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic dot_t trunc_dot(sum_t v);
    sum_t a;
    a = v + (v[SUM_W-1] ? sum_t'(FRAC_M1) : '0);
    return dot_t'(a >>> FB);
  endfunction

  function automatic shr_t trunc_scl(scl_t v);
    scl_t a;
    a = v + (v[SCW-1] ? scl_t'(FRAC_M1) : '0);
    return shr_t'(a >>> FB);
  endfunction

  function automatic comp_t sat(diff_t d);
    comp_t r;
    if (d > diff_t'(COMP_MAX)) r = COMP_MAX;
    else if (d < diff_t'(COMP_MIN)) r = COMP_MIN;
    else r = comp_t'(d);
    return r;
  endfunction

endpackage

// ===== hw/rtl/vr3_if.sv =====
// ----------------------------------------------------------------------------
// Vector rejection channels
// Request channel (up and view vectors) and response channel (result).
// ----------------------------------------------------------------------------
interface vr3_in_if;
  logic          valid;
  logic          ready;
  vr3_pkg::comp_t up_x;
  vr3_pkg::comp_t up_y;
  vr3_pkg::comp_t up_z;
  vr3_pkg::comp_t view_x;
  vr3_pkg::comp_t view_y;
  vr3_pkg::comp_t view_z;

  modport source (output valid, up_x, up_y, up_z, view_x, view_y, view_z, input ready);
  modport sink (input valid, up_x, up_y, up_z, view_x, view_y, view_z, output ready);
endinterface

interface vr3_out_if;
  logic          valid;
  logic          ready;
  vr3_pkg::comp_t out_x;
  vr3_pkg::comp_t out_y;
  vr3_pkg::comp_t out_z;
  logic [1:0]    status;

  modport source (output valid, out_x, out_y, out_z, status, input ready);
  modport sink (input valid, out_x, out_y, out_z, status, output ready);
endinterface

// ===== hw/rtl/vr3_isqrt.sv =====
// ----------------------------------------------------------------------------
// Vector rejection square root
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module vr3_isqrt (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  vr3_pkg::lsq_t          lensq_i,
  input  vr3_pkg::side_t         side_i,
  output logic                   valid_o,
  output logic [vr3_pkg::CW-1:0] root_o,
  output vr3_pkg::side_t         side_o
);

  logic [vr3_pkg::SQ_RW-1:0] rem_q  [vr3_pkg::CW];
  logic [vr3_pkg::CW-1:0]    root_q [vr3_pkg::CW];
  vr3_pkg::lsq_t             n_q    [vr3_pkg::CW];
  vr3_pkg::side_t            side_q [vr3_pkg::CW];
  logic                      vld_q  [vr3_pkg::CW];

  for (genvar g = 0; g < vr3_pkg::CW; g++) begin : g_stage
    logic [vr3_pkg::SQ_RW-1:0] rem_in, rem_sh, trial;
    logic [vr3_pkg::CW-1:0]    root_in;
    vr3_pkg::lsq_t             n_in;
    vr3_pkg::side_t            side_in;
    logic                      vld_in;

    if (g == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign n_in    = lensq_i;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
      assign n_in    = n_q[g-1];
      assign side_in = side_q[g-1];
      assign vld_in  = vld_q[g-1];
    end

    assign rem_sh = {rem_in[vr3_pkg::SQ_RW-3:0], n_in[vr3_pkg::LSQ_W-1 -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (en_i) begin
        vld_q[g] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[g]    <= n_in << 2;
        side_q[g] <= side_in;
        if (rem_sh >= trial) begin
          rem_q[g]  <= rem_sh - trial;
          root_q[g] <= {root_in[vr3_pkg::CW-2:0], 1'b1};
        end else begin
          rem_q[g]  <= rem_sh;
          root_q[g] <= {root_in[vr3_pkg::CW-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = vld_q[vr3_pkg::CW-1];
  assign root_o  = root_q[vr3_pkg::CW-1];
  assign side_o  = side_q[vr3_pkg::CW-1];

endmodule

// ===== hw/rtl/vr3_div.sv =====
// ----------------------------------------------------------------------------
// Vector rejection normalizer
// Three-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module vr3_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [vr3_pkg::CW-1:0]    len_i,
  input  vr3_pkg::side_t            side_i,
  output logic                      valid_o,
  output vr3_pkg::unit_t [2:0]      unit_o,
  output vr3_pkg::side_t            side_o
);

  logic [2:0][vr3_pkg::DW-1:0] rem_q  [vr3_pkg::QB];
  logic [2:0][vr3_pkg::QB-1:0] quo_q  [vr3_pkg::QB];
  logic [2:0]                  neg_q  [vr3_pkg::QB];
  logic [vr3_pkg::CW-1:0]      len_q  [vr3_pkg::QB];
  vr3_pkg::side_t              side_q [vr3_pkg::QB];
  logic                        vld_q  [vr3_pkg::QB];

  for (genvar g = 0; g < vr3_pkg::QB; g++) begin : g_stage
    logic [2:0][vr3_pkg::DW-1:0] rem_in;
    logic [2:0][vr3_pkg::QB-1:0] quo_in;
    logic [2:0]                  neg_in;
    logic [vr3_pkg::CW-1:0]      len_in;
    logic [vr3_pkg::DW-1:0]      dvs;
    vr3_pkg::side_t              side_in;
    logic                        vld_in;

    if (g == 0) begin : g_first
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign rem_in[l] = {vr3_pkg::mag(side_i.view[l]), {vr3_pkg::FB{1'b0}}};
        assign neg_in[l] = side_i.view[l][vr3_pkg::CW-1];
      end
      assign quo_in  = '0;
      assign len_in  = len_i;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[g-1];
      assign quo_in  = quo_q[g-1];
      assign neg_in  = neg_q[g-1];
      assign len_in  = len_q[g-1];
      assign side_in = side_q[g-1];
      assign vld_in  = vld_q[g-1];
    end

    assign dvs = {{vr3_pkg::FB{1'b0}}, len_in} << (vr3_pkg::QB - 1 - g);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (en_i) begin
        vld_q[g] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        len_q[g]  <= len_in;
        side_q[g] <= side_in;
        neg_q[g]  <= neg_in;
        for (int l = 0; l < 3; l++) begin
          if (rem_in[l] >= dvs) begin
            rem_q[g][l] <= rem_in[l] - dvs;
            quo_q[g][l] <= {quo_in[l][vr3_pkg::QB-2:0], 1'b1};
          end else begin
            rem_q[g][l] <= rem_in[l];
            quo_q[g][l] <= {quo_in[l][vr3_pkg::QB-2:0], 1'b0};
          end
        end
      end
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_out
    vr3_pkg::unit_t q_ext;
    assign q_ext     = vr3_pkg::unit_t'(quo_q[vr3_pkg::QB-1][l]);
    assign unit_o[l] = neg_q[vr3_pkg::QB-1][l] ? -q_ext : q_ext;
  end

  assign valid_o = vld_q[vr3_pkg::QB-1];
  assign side_o  = side_q[vr3_pkg::QB-1];

endmodule

// ===== hw/rtl/vr3_proj.sv =====
// ----------------------------------------------------------------------------
// Vector rejection projection
// Dot product, scaling, difference, saturation and status.
// ----------------------------------------------------------------------------
module vr3_proj (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  vr3_pkg::unit_t [2:0] unit_i,
  input  vr3_pkg::side_t       side_i,
  output logic                 valid_o,
  output vr3_pkg::comp_t       out_x_o,
  output vr3_pkg::comp_t       out_y_o,
  output vr3_pkg::comp_t       out_z_o,
  output vr3_pkg::status_e     status_o
);

  logic [3:0] vld_q;
  logic [3:0] zero_q;
  vr3_pkg::comp_t [2:0] up1_q, up2_q, up3_q, up4_q;
  vr3_pkg::unit_t [2:0] u1_q, u2_q;
  vr3_pkg::prod_t [2:0] prod_q;
  vr3_pkg::dot_t        dot_q;
  vr3_pkg::scl_t  [2:0] scl_q;
  vr3_pkg::diff_t [2:0] diff_q;
  vr3_pkg::sum_t        sum;

  assign sum = vr3_pkg::sum_t'(prod_q[0]) + vr3_pkg::sum_t'(prod_q[1])
             + vr3_pkg::sum_t'(prod_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q <= {zero_q[2:0], side_i.zero};
      up1_q  <= side_i.up;
      up2_q  <= up1_q;
      up3_q  <= up2_q;
      up4_q  <= up3_q;
      u1_q   <= unit_i;
      u2_q   <= u1_q;
      dot_q  <= vr3_pkg::trunc_dot(sum);
      for (int i = 0; i < 3; i++) begin
        prod_q[i] <= vr3_pkg::prod_t'(side_i.up[i]) * vr3_pkg::prod_t'(unit_i[i]);
        scl_q[i]  <= vr3_pkg::scl_t'(dot_q) * vr3_pkg::scl_t'(u2_q[i]);
        diff_q[i] <= vr3_pkg::diff_t'(up3_q[i])
                   - vr3_pkg::diff_t'(vr3_pkg::trunc_scl(scl_q[i]));
      end
    end
  end

  always_comb begin
    priority if (zero_q[3]) begin
      status_o = vr3_pkg::ST_ZERO;
      out_x_o  = '0;
      out_y_o  = '0;
      out_z_o  = '0;
    end else if (diff_q == '0) begin
      status_o = vr3_pkg::ST_PARALLEL;
      out_x_o  = up4_q[0];
      out_y_o  = up4_q[1];
      out_z_o  = up4_q[2];
    end else begin
      status_o = vr3_pkg::ST_OK;
      out_x_o  = vr3_pkg::sat(diff_q[0]);
      out_y_o  = vr3_pkg::sat(diff_q[1]);
      out_z_o  = vr3_pkg::sat(diff_q[2]);
    end
  end

  assign valid_o = vld_q[3];

endmodule

// ===== hw/rtl/vector_rejection_3d.sv =====
// ----------------------------------------------------------------------------
// Vector rejection 3D
// Component of an up vector normal to a view vector, Q16.16, saturated.
//
//   channel  dir  payload                                   handshake
//   req_i    in   up_x up_y up_z view_x view_y view_z       valid/ready
//   rsp_o    out  out_x out_y out_z status                  valid/ready
//
// One request per cycle unless rsp_o stalls; data passes the squares, the
// length sum, the 32-stage square root, the 17-stage divider and vr3_proj.
// Reset clears only the valid bits; the data registers are not reset.
// A stalled response freezes the whole pipeline, holding every request.
// ----------------------------------------------------------------------------
`include "vector_rejection_3d_macros.svh"

module vector_rejection_3d (
  input  logic      clk_i,
  input  logic      rst_ni,
  vr3_in_if.sink    req_i,
  vr3_out_if.source rsp_o
);

  logic                   en;
  logic                   sq_vld_q, ls_vld_q;
  vr3_pkg::lsq_t [2:0]    sq_q;
  vr3_pkg::side_t         sq_side_q, ls_side_q;
  vr3_pkg::side_t         ls_side_d;
  vr3_pkg::lsq_t          lensq_q;
  vr3_pkg::side_t         side_in, rt_side, dv_side;
  logic                   rt_vld, dv_vld, pj_vld;
  logic [vr3_pkg::CW-1:0] root;
  vr3_pkg::unit_t [2:0]   unit;
  vr3_pkg::comp_t         pj_x, pj_y, pj_z;
  vr3_pkg::status_e       pj_status;
  vr3_pkg::lsq_t          lensq_d;

  logic                   out_vld_q;
  vr3_pkg::comp_t         out_x_q, out_y_q, out_z_q;
  vr3_pkg::status_e       status_q;

  assign en          = !out_vld_q || rsp_o.ready;
  assign req_i.ready = en;

  assign side_in.up   = {req_i.up_z, req_i.up_y, req_i.up_x};
  assign side_in.view = {req_i.view_z, req_i.view_y, req_i.view_x};
  assign side_in.zero = 1'b0;

  assign lensq_d = sq_q[0] + sq_q[1] + sq_q[2];

  assign ls_side_d.up   = sq_side_q.up;
  assign ls_side_d.view = sq_side_q.view;
  assign ls_side_d.zero = (lensq_d == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q  <= 1'b0;
      ls_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      sq_vld_q  <= req_i.valid;
      ls_vld_q  <= sq_vld_q;
      out_vld_q <= pj_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_side_q <= side_in;
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= vr3_pkg::lsq_t'(vr3_pkg::mag(side_in.view[i]))
                 * vr3_pkg::lsq_t'(vr3_pkg::mag(side_in.view[i]));
      end
      lensq_q   <= lensq_d;
      ls_side_q <= ls_side_d;
      out_x_q   <= pj_x;
      out_y_q   <= pj_y;
      out_z_q   <= pj_z;
      status_q  <= pj_status;
    end
  end

  vr3_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ls_vld_q),
    .lensq_i (lensq_q),
    .side_i  (ls_side_q),
    .valid_o (rt_vld),
    .root_o  (root),
    .side_o  (rt_side)
  );

  vr3_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (rt_vld),
    .len_i   (root),
    .side_i  (rt_side),
    .valid_o (dv_vld),
    .unit_o  (unit),
    .side_o  (dv_side)
  );

  vr3_proj u_proj (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (dv_vld),
    .unit_i   (unit),
    .side_i   (dv_side),
    .valid_o  (pj_vld),
    .out_x_o  (pj_x),
    .out_y_o  (pj_y),
    .out_z_o  (pj_z),
    .status_o (pj_status)
  );

  assign rsp_o.valid  = out_vld_q;
  assign rsp_o.out_x  = out_x_q;
  assign rsp_o.out_y  = out_y_q;
  assign rsp_o.out_z  = out_z_q;
  assign rsp_o.status = status_q;

  `VR3_ASSERT(a_zero_out,
    (out_vld_q && status_q == vr3_pkg::ST_ZERO) |-> ({out_x_q, out_y_q, out_z_q} == '0),
    "zero-length view with nonzero result")
  `VR3_ASSERT(a_root_zero, (rt_vld && rt_side.zero) |-> (root == '0),
    "zero length with nonzero root")
  `VR3_ASSERT(a_stall_hold, (out_vld_q && !rsp_o.ready) |=> $stable(pj_vld),
    "pipeline moved during stall")

endmodule
